>>> rtl/stereo_balance_gain_smoother_macros.svh
// Assertion helpers shared by the RTL.
`ifndef STEREO_BALANCE_GAIN_SMOOTHER_MACROS_SVH
`define STEREO_BALANCE_GAIN_SMOOTHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SBGS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbgs assertion failed");

// Next-cycle implication, checked outside reset.
`define SBGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbgs assertion failed");

`endif

>>> rtl/sbgs_pkg.sv
package sbgs_pkg;

   localparam int RAMP_LEN  = 64;
   localparam int DIV_STEPS = 20;

   localparam logic signed [19:0] GAIN_UNITY  = 20'sd65536;
   localparam logic signed [19:0] GAIN_MAX    = 20'sd524287;
   localparam logic signed [19:0] GAIN_MIN    = -20'sd524288;
   localparam logic signed [20:0] SNAP_THRESH = 21'sd131;
   localparam logic signed [19:0] SMOOTH_Q16  = 20'sd58982;
   localparam logic signed [23:0] S24_MAX     = 24'sd8388607;
   localparam logic signed [23:0] S24_MIN     = -24'sd8388608;

   localparam logic REG_BALANCE = 1'b0;
   localparam logic REG_MASTER  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_INTERP,
      ST_SMOOTH_MUL,
      ST_SMOOTH_ADD,
      ST_MUL_SRC,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACC,
      ST_FINISH
   } state_type;

   // Balance law: far side falls linearly, near side stays at unity.
   function automatic logic [16:0] target_gain(input logic [16:0] pos, input logic ch);
      logic [16:0] p;
      logic [17:0] dbl;
      logic [16:0] g;
      p   = (pos > 17'd65536) ? 17'd65536 : pos;
      dbl = {p, 1'b0};
      g   = 17'd65536;
      if (ch == 1'b0) begin
         if (p > 17'd32768) begin
            g = 17'(18'd131072 - dbl);
         end
      end else begin
         if (p < 17'd32768) begin
            g = dbl[16:0];
         end
      end
      return g;
   endfunction

   function automatic logic signed [19:0] sat_gain(input logic signed [29:0] v);
      logic signed [19:0] r;
      if (v > 30'(GAIN_MAX)) begin
         r = GAIN_MAX;
      end else if (v < 30'(GAIN_MIN)) begin
         r = GAIN_MIN;
      end else begin
         r = v[19:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/sbgs_req_if.sv
interface sbgs_req_if;
   logic               valid;
   logic               ready;
   logic               channel;
   logic signed [23:0] source_sample;
   logic signed [23:0] mix_in;
   logic               block_start;
   logic [13:0]        block_length;
   logic               automated;
   logic [16:0]        auto_position;

   modport source (
      output valid, channel, source_sample, mix_in, block_start, block_length,
             automated, auto_position,
      input  ready
   );
   modport sink (
      input  valid, channel, source_sample, mix_in, block_start, block_length,
             automated, auto_position,
      output ready
   );
endinterface

>>> rtl/sbgs_rsp_if.sv
interface sbgs_rsp_if;
   logic               valid;
   logic               ready;
   logic               out_channel;
   logic signed [23:0] out_sample;

   modport source (output valid, out_channel, out_sample, input ready);
   modport sink (input valid, out_channel, out_sample, output ready);
endinterface

>>> rtl/stereo_balance_gain_smoother.sv
// Channel   Dir  Handshake           Payload
// req_chan  in   valid/ready         channel, samples, block info, automation
// rsp_chan  out  valid/ready         out_channel, out_sample
// csr_*     in   csr_we (no wait)    csr_addr selects register, csr_wdata
//
// One item at a time through a shared 24x20 multiplier and a radix-2 divider.
// Normal item: prep, source multiply, master multiply lo/hi, accumulate, finish;
// automated skips lo/hi; ramp sample adds interp/smooth; ramp start adds the divide.
// Reset (synchronous) restores unity gains and register defaults.
// The result sits in an output register; a stalled rsp_chan holds the next item
// in its last state until the register frees up.
`include "stereo_balance_gain_smoother_macros.svh"

module stereo_balance_gain_smoother (
   input  logic        clock,
   input  logic        reset,
   sbgs_req_if.sink    req_chan,
   sbgs_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [17:0] csr_wdata
);

   sbgs_pkg::state_type state_ff, state_in;

   logic [16:0] balance_ff;
   logic [17:0] master_ff;

   logic signed [19:0] applied_ff [2];
   logic signed [19:0] interp_ff  [2];
   logic signed [19:0] step_ff    [2];
   logic [6:0]         remain_ff  [2];

   // latched item
   logic               ch_ff;
   logic signed [23:0] src_ff;
   logic signed [23:0] mix_ff;
   logic               bstart_ff;
   logic [13:0]        blen_ff;
   logic               auto_ff;
   logic [16:0]        apos_ff;

   // divider
   logic [19:0] dq_ff;
   logic [5:0]  rem_ff;
   logic [4:0]  cnt_ff;
   logic [6:0]  lim_ff;
   logic        neg_ff;

   // multiplier and accumulation
   logic signed [23:0] mul_a;
   logic signed [19:0] mul_b;
   logic               mul_en;
   logic signed [43:0] prod_ff;
   logic signed [43:0] p1_ff;
   logic [39:0]        acc_ff;
   logic signed [28:0] term_ff;

   logic               out_valid_ff;
   logic               out_ch_ff;
   logic signed [23:0] out_sample_ff;

   // PREP decisions
   logic [16:0]        tgt;
   logic signed [20:0] err;
   logic               big_err;
   logic signed [20:0] num;
   logic [6:0]         lim;

   // divider step
   logic [6:0]         trial;
   logic               qbit;
   logic [19:0]        dq_next;
   logic signed [20:0] q_signed;
   logic               div_last;

   logic               out_free;
   logic               accept;

   assign accept   = req_chan.valid & req_chan.ready;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   assign tgt     = sbgs_pkg::target_gain(balance_ff, ch_ff);
   assign err     = 21'(applied_ff[ch_ff]) - $signed({4'b0, tgt});
   assign big_err = (err > sbgs_pkg::SNAP_THRESH) || (err < -sbgs_pkg::SNAP_THRESH);
   assign num     = $signed({4'b0, tgt}) - 21'(applied_ff[ch_ff]);

   always_comb begin
      if (blen_ff == 14'd0) begin
         lim = 7'd1;
      end else if (blen_ff > 14'(sbgs_pkg::RAMP_LEN)) begin
         lim = 7'(sbgs_pkg::RAMP_LEN);
      end else begin
         lim = blen_ff[6:0];
      end
   end

   // one restoring step per cycle
   assign trial    = {rem_ff, dq_ff[19]};
   assign qbit     = (trial >= lim_ff);
   assign dq_next  = {dq_ff[18:0], qbit};
   assign q_signed = neg_ff ? -$signed({1'b0, dq_next}) : $signed({1'b0, dq_next});
   assign div_last = (cnt_ff == 5'(sbgs_pkg::DIV_STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbgs_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = sbgs_pkg::ST_PREP;
            end
         end
         sbgs_pkg::ST_PREP: begin
            if (auto_ff) begin
               state_in = sbgs_pkg::ST_MUL_SRC;
            end else if (bstart_ff && big_err) begin
               state_in = sbgs_pkg::ST_DIV;
            end else if (bstart_ff) begin
               state_in = sbgs_pkg::ST_MUL_SRC;
            end else if (remain_ff[ch_ff] != 7'd0) begin
               state_in = sbgs_pkg::ST_INTERP;
            end else begin
               state_in = sbgs_pkg::ST_MUL_SRC;
            end
         end
         sbgs_pkg::ST_DIV: begin
            if (div_last) begin
               state_in = sbgs_pkg::ST_INTERP;
            end
         end
         sbgs_pkg::ST_INTERP:     state_in = sbgs_pkg::ST_SMOOTH_MUL;
         sbgs_pkg::ST_SMOOTH_MUL: state_in = sbgs_pkg::ST_SMOOTH_ADD;
         sbgs_pkg::ST_SMOOTH_ADD: state_in = sbgs_pkg::ST_MUL_SRC;
         sbgs_pkg::ST_MUL_SRC: begin
            state_in = auto_ff ? sbgs_pkg::ST_ACC : sbgs_pkg::ST_MUL_LO;
         end
         sbgs_pkg::ST_MUL_LO: state_in = sbgs_pkg::ST_MUL_HI;
         sbgs_pkg::ST_MUL_HI: state_in = sbgs_pkg::ST_ACC;
         sbgs_pkg::ST_ACC:    state_in = sbgs_pkg::ST_FINISH;
         sbgs_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = sbgs_pkg::ST_IDLE;
            end
         end
         default: state_in = sbgs_pkg::ST_IDLE;
      endcase
   end

   // outputs: handshake and multiplier operand select
   always_comb begin
      req_chan.ready = 1'b0;
      mul_en         = 1'b0;
      mul_a          = src_ff;
      mul_b          = applied_ff[ch_ff];
      case (state_ff)
         sbgs_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         sbgs_pkg::ST_SMOOTH_MUL: begin
            mul_en = 1'b1;
            mul_a  = 24'(21'(applied_ff[ch_ff]) - 21'(interp_ff[ch_ff]));
            mul_b  = sbgs_pkg::SMOOTH_Q16;
         end
         sbgs_pkg::ST_MUL_SRC: begin
            mul_en = 1'b1;
            mul_a  = src_ff;
            if (auto_ff) begin
               mul_b = $signed({3'b0, sbgs_pkg::target_gain(apos_ff, ch_ff)});
            end else begin
               mul_b = applied_ff[ch_ff];
            end
         end
         sbgs_pkg::ST_MUL_LO: begin
            mul_en = 1'b1;
            mul_a  = $signed({2'b0, prod_ff[21:0]});
            mul_b  = $signed({2'b0, master_ff});
         end
         sbgs_pkg::ST_MUL_HI: begin
            mul_en = 1'b1;
            mul_a  = 24'($signed(p1_ff[43:22]));
            mul_b  = $signed({2'b0, master_ff});
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbgs_pkg::ST_IDLE;
         balance_ff   <= 17'd32768;
         master_ff    <= 18'd65536;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            applied_ff[i] <= sbgs_pkg::GAIN_UNITY;
            interp_ff[i]  <= sbgs_pkg::GAIN_UNITY;
            step_ff[i]    <= '0;
            remain_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            case (csr_addr)
               sbgs_pkg::REG_BALANCE: balance_ff <= csr_wdata[16:0];
               sbgs_pkg::REG_MASTER:  master_ff  <= csr_wdata;
               default:               master_ff  <= master_ff;
            endcase
         end

         if (state_ff == sbgs_pkg::ST_FINISH && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end

         case (state_ff)
            sbgs_pkg::ST_PREP: begin
               if (!auto_ff && bstart_ff && !big_err) begin
                  applied_ff[ch_ff] <= $signed({3'b0, tgt});
                  interp_ff[ch_ff]  <= $signed({3'b0, tgt});
                  remain_ff[ch_ff]  <= '0;
               end
            end
            sbgs_pkg::ST_DIV: begin
               if (div_last) begin
                  step_ff[ch_ff]   <= sbgs_pkg::sat_gain(30'(q_signed));
                  remain_ff[ch_ff] <= lim_ff;
               end
            end
            sbgs_pkg::ST_INTERP: begin
               interp_ff[ch_ff] <= sbgs_pkg::sat_gain(
                  30'(interp_ff[ch_ff]) + 30'(step_ff[ch_ff]));
            end
            sbgs_pkg::ST_SMOOTH_ADD: begin
               applied_ff[ch_ff] <= sbgs_pkg::sat_gain(
                  30'(interp_ff[ch_ff]) + 30'(prod_ff + 44'sd32768 >>> 16));
               remain_ff[ch_ff]  <= remain_ff[ch_ff] - 7'd1;
            end
            default: begin
            end
         endcase
      end
   end

   // payload and datapath registers
   logic signed [29:0] res;
   logic signed [63:0] full;
   logic signed [43:0] rnd16;

   assign full  = (64'(prod_ff) <<< 22) + $signed({24'b0, acc_ff}) + 64'sd2147483648;
   assign rnd16 = prod_ff + 44'sd32768;
   assign res   = 30'(mix_ff) + 30'(term_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff     <= req_chan.channel;
         src_ff    <= req_chan.source_sample;
         mix_ff    <= req_chan.mix_in;
         bstart_ff <= req_chan.block_start;
         blen_ff   <= req_chan.block_length;
         auto_ff   <= req_chan.automated;
         apos_ff   <= req_chan.auto_position;
      end
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      case (state_ff)
         sbgs_pkg::ST_PREP: begin
            neg_ff <= num[20];
            dq_ff  <= num[20] ? 20'(-num) : num[19:0];
            rem_ff <= '0;
            cnt_ff <= '0;
            lim_ff <= lim;
         end
         sbgs_pkg::ST_DIV: begin
            dq_ff  <= dq_next;
            rem_ff <= qbit ? 6'(trial - lim_ff) : trial[5:0];
            cnt_ff <= cnt_ff + 5'd1;
         end
         sbgs_pkg::ST_MUL_LO: begin
            p1_ff <= prod_ff;
         end
         sbgs_pkg::ST_MUL_HI: begin
            acc_ff <= prod_ff[39:0];
         end
         sbgs_pkg::ST_ACC: begin
            if (auto_ff) begin
               term_ff <= 29'($signed(rnd16[43:16]));
            end else begin
               term_ff <= full[60:32];
            end
         end
         sbgs_pkg::ST_FINISH: begin
            if (out_free) begin
               out_ch_ff <= ch_ff;
               if (res > 30'(sbgs_pkg::S24_MAX)) begin
                  out_sample_ff <= sbgs_pkg::S24_MAX;
               end else if (res < 30'(sbgs_pkg::S24_MIN)) begin
                  out_sample_ff <= sbgs_pkg::S24_MIN;
               end else begin
                  out_sample_ff <= res[23:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_channel = out_ch_ff;
   assign rsp_chan.out_sample  = out_sample_ff;

   `SBGS_ASSERT_NEXT(a_accept_to_prep, clock, reset, accept, state_ff == sbgs_pkg::ST_PREP)
   `SBGS_ASSERT_IMPL(a_ramp_bound, clock, reset, 1'b1,
      remain_ff[0] <= 7'(sbgs_pkg::RAMP_LEN) && remain_ff[1] <= 7'(sbgs_pkg::RAMP_LEN))
   `SBGS_ASSERT_NEXT(a_div_done, clock, reset,
      state_ff == sbgs_pkg::ST_DIV && div_last, state_ff == sbgs_pkg::ST_INTERP)
   `SBGS_ASSERT_NEXT(a_finish_hold, clock, reset,
      state_ff == sbgs_pkg::ST_FINISH && !out_free, state_ff == sbgs_pkg::ST_FINISH)
   `SBGS_ASSERT_NEXT(a_auto_keeps_gain, clock, reset,
      state_ff == sbgs_pkg::ST_PREP && auto_ff, $stable(applied_ff[ch_ff]))

endmodule
